// ===== src/ibes_pkg.sv =====
// Package for the image border extension store: status and mode codes,
// register indexes, the control word passed between front and back, axis mapping.
// No dependencies.
`default_nettype none
package ibes_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_BORDER = 16;
    localparam int DEF_PIXEL_BITS = 32;

    // fixed field widths
    localparam int COORD_BITS = 10;
    localparam int DIM_BITS   = 9;
    localparam int BORD_BITS  = 5;
    localparam int MODE_BITS  = 2;
    localparam int CFG_BITS   = 9;
    localparam int IDX_BITS   = 2;
    // signed working width for coordinate arithmetic
    localparam int CW         = 12;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_BORDER = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_MODE   = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [MODE_BITS-1:0] MODE_ODD  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_EVEN = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_REPL = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_WIDE  = 2'd2
    } t_status;

    typedef struct packed {
        logic    is_write;
        logic    use_mem;
        t_status status;
    } t_ctl;

    // Map one padded coordinate onto 0..n-1; the range is checked by the caller.
    function automatic logic [DIM_BITS-1:0] map_axis(
        input logic signed [CW-1:0] x,
        input logic [DIM_BITS-1:0]  n,
        input logic [MODE_BITS-1:0] mode
    );
        logic signed [CW-1:0] ns;
        logic signed [CW-1:0] res;
        ns = $signed({{(CW-DIM_BITS){1'b0}}, n});
        if (x >= 0 && x < ns) begin
            res = x;
        end else if (mode == MODE_ODD) begin
            res = (x < 0) ? -x : (ns <<< 1) - CW'(2) - x;
        end else if (mode == MODE_EVEN) begin
            res = (x < 0) ? -CW'(1) - x : (ns <<< 1) - CW'(1) - x;
        end else begin
            res = (x < 0) ? CW'(0) : ns - CW'(1);
        end
        return DIM_BITS'(res);
    endfunction

endpackage
`default_nettype wire

// ===== src/image_border_extension_store.sv =====
// Image border extension store: pixel store with reflect/replicate padded reads.
// Timing: the result strobe of each request is registered in the back part.
// Throughput: one request per cycle while busy is low; the back part drains one
// queue entry a cycle; its single memory port serves the write or read of that entry.
// Reset: configuration returns to 256 x 256, no border, odd reflection; the queue
// empties; the image memory keeps its contents and is not cleared.
`default_nettype none
module image_border_extension_store #(
    parameter int MAX_WIDTH  = ibes_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ibes_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = ibes_pkg::DEF_MAX_BORDER,
    parameter int PIXEL_BITS = ibes_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_action,
    input  wire logic signed [ibes_pkg::COORD_BITS-1:0] i_col,
    input  wire logic signed [ibes_pkg::COORD_BITS-1:0] i_row,
    input  wire logic [PIXEL_BITS-1:0]                  i_pixel_in,
    input  wire logic                                   i_cfg_we,
    input  wire logic [ibes_pkg::IDX_BITS-1:0]          i_cfg_index,
    input  wire logic [ibes_pkg::CFG_BITS-1:0]          i_cfg_data,
    output logic                                        o_done,
    output logic [PIXEL_BITS-1:0]                       o_pixel_out,
    output logic [1:0]                                  o_status
);
    import ibes_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CTL_W  = $bits(t_ctl);
    localparam int Q_W    = CTL_W + ADDR_W + PIXEL_BITS;

    t_ctl              f_ctl, q_ctl;
    logic [ADDR_W-1:0] f_addr, q_addr;
    logic [PIXEL_BITS-1:0] q_pixel;
    logic [Q_W-1:0]    q_out;
    logic              q_full, q_empty, push, pop;

    // accept a request whenever the queue has room
    assign busy = q_full;
    assign push = start && !q_full;
    // the receiver never stalls, so drain one entry every cycle the queue is not empty
    assign pop  = !q_empty;

    // classify the request and form its memory address
    ibes_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BORDER (MAX_BORDER),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_action),
        .i_col       (i_col),
        .i_row       (i_row),
        .o_ctl       (f_ctl),
        .o_addr      (f_addr)
    );

    // hold classified requests until the back part takes them
    ibes_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_addr, i_pixel_in}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign q_ctl   = q_out[Q_W-1 -: CTL_W];
    assign q_addr  = q_out[PIXEL_BITS +: ADDR_W];
    assign q_pixel = q_out[PIXEL_BITS-1:0];

    // store or fetch the pixel and drive the result strobe
    ibes_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .ADDR_W     (ADDR_W),
        .DEPTH      (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (pop),
        .i_ctl       (q_ctl),
        .i_addr      (q_addr),
        .i_pixel     (q_pixel),
        .o_done      (o_done),
        .o_pixel_out (o_pixel_out),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

// ===== src/ibes_front.sv =====
// Front part: configuration registers, range and border checks, axis mapping
// and address forming for each request. Depends on ibes_pkg.
`default_nettype none
module ibes_front #(
    parameter int MAX_WIDTH  = ibes_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ibes_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = ibes_pkg::DEF_MAX_BORDER,
    parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ibes_pkg::IDX_BITS-1:0]        i_cfg_index,
    input  wire logic [ibes_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  wire logic                                 i_action,
    input  wire logic signed [ibes_pkg::COORD_BITS-1:0] i_col,
    input  wire logic signed [ibes_pkg::COORD_BITS-1:0] i_row,
    output ibes_pkg::t_ctl                            o_ctl,
    output logic [ADDR_W-1:0]                         o_addr
);
    import ibes_pkg::*;

    localparam int W_LIM = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
    localparam int H_LIM = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int B_LIM = (MAX_BORDER > 31)  ? 31  : MAX_BORDER;

    logic [DIM_BITS-1:0]  r_img_w, r_img_h;
    logic [BORD_BITS-1:0] r_bord;
    logic [MODE_BITS-1:0] r_mode;

    logic [DIM_BITS-1:0]  w, h, mc, mr;
    logic [BORD_BITS-1:0] b;
    logic [MODE_BITS-1:0] mode;
    logic signed [CW-1:0] cs, rs, ws, hs, bs;
    logic                 too_wide, out_pad, out_img;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= DIM_BITS'(256);
            r_img_h <= DIM_BITS'(256);
            r_bord  <= '0;
            r_mode  <= MODE_ODD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_img_w <= i_cfg_data[DIM_BITS-1:0];
                REG_HEIGHT: r_img_h <= i_cfg_data[DIM_BITS-1:0];
                REG_BORDER: r_bord  <= i_cfg_data[BORD_BITS-1:0];
                REG_MODE:   r_mode  <= i_cfg_data[MODE_BITS-1:0];
                default:    r_mode  <= r_mode;
            endcase
        end
    end

    always_comb begin
        // saturate the configuration to its legal range
        w = (r_img_w == '0) ? DIM_BITS'(1)
          : ((r_img_w > DIM_BITS'(W_LIM)) ? DIM_BITS'(W_LIM) : r_img_w);
        h = (r_img_h == '0) ? DIM_BITS'(1)
          : ((r_img_h > DIM_BITS'(H_LIM)) ? DIM_BITS'(H_LIM) : r_img_h);
        b = (r_bord > BORD_BITS'(B_LIM)) ? BORD_BITS'(B_LIM) : r_bord;
        mode = (r_mode > MODE_REPL) ? MODE_REPL : r_mode;

        cs = CW'(i_col);
        rs = CW'(i_row);
        ws = $signed({{(CW-DIM_BITS){1'b0}}, w});
        hs = $signed({{(CW-DIM_BITS){1'b0}}, h});
        bs = $signed({{(CW-BORD_BITS){1'b0}}, b});

        if (mode == MODE_ODD) begin
            too_wide = ({4'b0, b} >= w) || ({4'b0, b} >= h);
        end else if (mode == MODE_EVEN) begin
            too_wide = ({4'b0, b} > w) || ({4'b0, b} > h);
        end else begin
            too_wide = 1'b0;
        end

        out_pad = (cs < -bs) || (cs >= ws + bs) || (rs < -bs) || (rs >= hs + bs);
        out_img = (cs < 0) || (cs >= ws) || (rs < 0) || (rs >= hs);

        mc = map_axis(cs, w, mode);
        mr = map_axis(rs, h, mode);
        o_addr = ADDR_W'(32'(mr) * MAX_WIDTH) + ADDR_W'(mc);

        if (i_action == ACT_WRITE) begin
            o_ctl.status = out_img ? ST_RANGE : ST_OK;
        end else if (too_wide) begin
            o_ctl.status = ST_WIDE;
        end else begin
            o_ctl.status = out_pad ? ST_RANGE : ST_OK;
        end
        o_ctl.is_write = (i_action == ACT_WRITE) && !out_img;
        o_ctl.use_mem  = (i_action == ACT_READ) && !too_wide && !out_pad;
    end

endmodule
`default_nettype wire

// ===== src/ibes_queue.sv =====
// Short FIFO between the front and back parts.
// Depends on ibes_pkg for the default depth.
`default_nettype none
module ibes_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = ibes_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [DATA_W-1:0]      o_data
);
    import ibes_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/ibes_back.sv =====
// Back part: the image memory, one write or one registered read per request,
// and the result register. Depends on ibes_pkg.
`default_nettype none
module ibes_back #(
    parameter int PIXEL_BITS = ibes_pkg::DEF_PIXEL_BITS,
    parameter int ADDR_W     = 16,
    parameter int DEPTH      = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire ibes_pkg::t_ctl        i_ctl,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [PIXEL_BITS-1:0] i_pixel,
    output logic                       o_done,
    output logic [PIXEL_BITS-1:0]      o_pixel_out,
    output logic [1:0]                 o_status
);
    import ibes_pkg::*;

    logic [PIXEL_BITS-1:0] r_mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rdata;
    logic                  r_valid, r_use;
    t_status               r_status;

    always_ff @(posedge i_clk) begin
        if (i_valid && i_ctl.is_write) begin
            r_mem[i_addr] <= i_pixel;
        end
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_use    <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_valid  <= i_valid;
            r_use    <= i_valid && i_ctl.use_mem;
            r_status <= i_ctl.status;
        end
    end

    assign o_done      = r_valid;
    assign o_pixel_out = r_use ? r_rdata : '0;
    assign o_status    = r_status;

endmodule
`default_nettype wire
